>>> rtl/rsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsa_pkg;

   localparam int SEQ_W      = 32;
   localparam int THREAD_W   = 3;
   localparam int STAGE_W    = 4;
   localparam int CMD_W      = 8;
   localparam int SLOT_IN_W  = 3;
   localparam int SLOT_OUT_W = 3;
   localparam int MASK_W     = 8;
   localparam int COUNT_W    = 4;

   // front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_FREE    = 2'd1,
      OP_SQUASH  = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [SEQ_W-1:0]      seq;
      logic [THREAD_W-1:0]   thread;
      logic [STAGE_W-1:0]    stage;
      logic [CMD_W-1:0]      command;
      logic [SLOT_IN_W-1:0]  slot_in;
      logic                  slot_bad;
   } item_type;

   typedef struct packed {
      logic                  granted;
      logic [SLOT_OUT_W-1:0] slot_out;
      logic                  was_held;
      logic [STAGE_W-1:0]    stage_out;
      logic [MASK_W-1:0]     squashed_mask;
      logic [COUNT_W-1:0]    free_count;
      logic                  bad_free;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/rsa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rsa_front #(
   parameter int SLOT_COUNT = 8
) (
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_req_type,
   input  wire logic [rsa_pkg::SEQ_W-1:0]     req_seq_num,
   input  wire logic [rsa_pkg::THREAD_W-1:0]  req_thread_id,
   input  wire logic [rsa_pkg::STAGE_W-1:0]   req_stage_num,
   input  wire logic [rsa_pkg::CMD_W-1:0]     req_command,
   input  wire logic [rsa_pkg::SLOT_IN_W-1:0] req_slot_in,
   input  wire logic                          q_full,
   output logic                               q_push,
   output rsa_pkg::item_type                  q_item
);
   import rsa_pkg::*;

   // accept whenever the queue has room; decode the opcode and
   // flag a free of a slot index past the table
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item.op       = op_type'(req_req_type);
      q_item.seq      = req_seq_num;
      q_item.thread   = req_thread_id;
      q_item.stage    = req_stage_num;
      q_item.command  = req_command;
      q_item.slot_in  = req_slot_in;
      q_item.slot_bad = (32'(req_slot_in) >= 32'(SLOT_COUNT));
   end

endmodule
`default_nettype wire

>>> rtl/rsa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rsa_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rsa_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output rsa_pkg::item_type      item
);
   import rsa_pkg::*;

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign valid   = (count_ff != '0);
   assign item    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/rsa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rsa_back #(
   parameter int SLOT_COUNT = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire rsa_pkg::item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   output rsa_pkg::result_type    rsp_word,
   input  wire logic              rsp_ready
);
   import rsa_pkg::*;

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(SLOT_COUNT);
   localparam logic [CW:0]   WRAP_SUM = (CW + 1)'(SLOT_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_GRANT,
      S_FREE,
      S_SQHIT,
      S_SCAN,
      S_REPORT
   } state_type;

   state_type             state_ff, state_in;
   item_type              cur_ff;
   logic [IW-1:0]         head_ff, head_in;
   logic [CW-1:0]         used_ff, used_in;
   logic [SLOT_COUNT-1:0] valid_ff, done_ff, fifo_written_ff;
   logic [SEQ_W-1:0]      seq_ff    [SLOT_COUNT];
   logic [THREAD_W-1:0]   thread_ff [SLOT_COUNT];
   logic                  hit_ff;
   logic [IW-1:0]         hit_idx_ff;
   logic [SLOT_COUNT-1:0] sq_vec_ff, mask_ff;
   logic [IW-1:0]         scan_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff, result_in;

   // free list and per-slot payload memories
   logic [IW-1:0]         fifo_mem [SLOT_COUNT];
   logic [STAGE_W-1:0]    stage_mem [SLOT_COUNT];
   logic [CMD_W-1:0]      cmd_mem [SLOT_COUNT];
   logic [IW-1:0]         fifo_rd_ff, fifo_rd_addr_ff;
   logic                  fifo_rd_written_ff;
   logic [STAGE_W-1:0]    stage_rd_ff;

   logic [SLOT_COUNT-1:0] match_vec, squash_vec;
   logic                  match_any;
   logic [IW-1:0]         match_idx;
   logic [CW:0]           tail_sum;
   logic [IW-1:0]         tail_idx, alloc_idx, sidx, rel_idx;
   logic                  out_free, free_ok, rel_en, fifo_push, alloc_en, emit;

   // parallel lanes: re-request match and squash hits
   always_comb begin
      match_idx = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match_vec[i]  = valid_ff[i] && (seq_ff[i] == cur_ff.seq);
         squash_vec[i] = valid_ff[i] && (thread_ff[i] == cur_ff.thread)
                         && (seq_ff[i] > cur_ff.seq);
      end
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_idx = IW'(i);
         end
      end
   end
   assign match_any = |match_vec;

   assign tail_sum  = (CW + 1)'(head_ff) + (CW + 1)'(used_ff);
   assign tail_idx  = (tail_sum >= WRAP_SUM) ? IW'(tail_sum - WRAP_SUM) : IW'(tail_sum);
   // an entry never written still holds its reset index
   assign alloc_idx = fifo_rd_written_ff ? fifo_rd_ff : fifo_rd_addr_ff;
   assign sidx      = IW'(cur_ff.slot_in);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign free_ok   = !cur_ff.slot_bad && valid_ff[sidx];
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      rel_en  = 1'b0;
      rel_idx = sidx;
      if (state_ff == S_FREE) begin
         rel_en = out_free && free_ok;
      end else if (state_ff == S_SCAN) begin
         rel_en  = sq_vec_ff[scan_ff];
         rel_idx = scan_ff;
      end
   end
   assign fifo_push = rel_en && (used_ff < FULL_CNT);
   assign alloc_en  = (state_ff == S_GRANT) && out_free && !hit_ff && (used_ff != '0);

   always_comb begin
      head_in = head_ff;
      used_in = used_ff;
      if (alloc_en) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
         used_in = used_ff - 1'b1;
      end else if (fifo_push) begin
         used_in = used_ff + 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      emit      = 1'b0;
      result_in = '0;
      result_in.free_count = COUNT_W'(used_in);
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  OP_REQUEST: state_in = S_MATCH;
                  OP_FREE:    state_in = S_FREE;
                  OP_SQUASH:  state_in = S_SQHIT;
                  default:    state_in = S_REPORT;
               endcase
            end
         end
         S_MATCH: state_in = S_GRANT;
         S_GRANT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (hit_ff) begin
                  result_in.granted   = 1'b1;
                  result_in.was_held  = 1'b1;
                  result_in.slot_out  = SLOT_OUT_W'(hit_idx_ff);
                  result_in.stage_out = stage_rd_ff;
               end else if (alloc_en) begin
                  result_in.granted   = 1'b1;
                  result_in.slot_out  = SLOT_OUT_W'(alloc_idx);
                  result_in.stage_out = cur_ff.stage;
               end
            end
         end
         S_FREE: begin
            if (out_free) begin
               emit               = 1'b1;
               state_in           = S_IDLE;
               result_in.bad_free = !free_ok;
            end
         end
         S_SQHIT: state_in = S_SCAN;
         S_SCAN: begin
            if (scan_ff == LAST_IDX) begin
               state_in = S_REPORT;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               emit                    = 1'b1;
               state_in                = S_IDLE;
               result_in.squashed_mask = MASK_W'(mask_ff);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         head_ff         <= '0;
         used_ff         <= FULL_CNT;
         valid_ff        <= '0;
         done_ff         <= '0;
         fifo_written_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         used_ff  <= used_in;
         if (q_pop) begin
            cur_ff  <= q_item;
            mask_ff <= '0;
         end
         if (state_ff == S_MATCH) begin
            hit_ff     <= match_any;
            hit_idx_ff <= match_idx;
         end
         if (state_ff == S_SQHIT) begin
            sq_vec_ff <= squash_vec;
            scan_ff   <= '0;
         end
         if (state_ff == S_SCAN) begin
            scan_ff <= scan_ff + 1'b1;
            if (rel_en) begin
               mask_ff[scan_ff] <= 1'b1;
            end
         end
         if (alloc_en) begin
            valid_ff[alloc_idx]  <= 1'b1;
            done_ff[alloc_idx]   <= 1'b1;
            seq_ff[alloc_idx]    <= cur_ff.seq;
            thread_ff[alloc_idx] <= cur_ff.thread;
         end
         if (rel_en) begin
            valid_ff[rel_idx] <= 1'b0;
            done_ff[rel_idx]  <= 1'b0;
         end
         if (fifo_push) begin
            fifo_written_ff[tail_idx] <= 1'b1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= result_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem[tail_idx] <= rel_idx;
      end
      if (state_ff == S_MATCH) begin
         fifo_rd_ff         <= fifo_mem[head_ff];
         fifo_rd_written_ff <= fifo_written_ff[head_ff];
         fifo_rd_addr_ff    <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc_en) begin
         stage_mem[alloc_idx] <= cur_ff.stage;
         cmd_mem[alloc_idx]   <= cur_ff.command;
      end
      if (state_ff == S_MATCH) begin
         stage_rd_ff <= stage_mem[match_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/resource_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// Slot allocator with a FIFO free list, re-request match and thread squash.
// A request passes the back-end states MATCH and GRANT, a free FREE, an unused
// opcode REPORT, a squash SQHIT, SCAN (one slot scanned a cycle) and REPORT.
// The back end works one word at a time, taking the next only once the last
// result is registered; a 2-deep queue lets the front take words meanwhile.
// Reset: synchronous; slots invalid, free list back to 0..SLOT_COUNT-1 at once.
module resource_slot_allocator #(
   parameter int SLOT_COUNT = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_req_type,
   input  wire logic [rsa_pkg::SEQ_W-1:0]      req_seq_num,
   input  wire logic [rsa_pkg::THREAD_W-1:0]   req_thread_id,
   input  wire logic [rsa_pkg::STAGE_W-1:0]    req_stage_num,
   input  wire logic [rsa_pkg::CMD_W-1:0]      req_command,
   input  wire logic [rsa_pkg::SLOT_IN_W-1:0]  req_slot_in,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_granted,
   output logic [rsa_pkg::SLOT_OUT_W-1:0]      rsp_slot_out,
   output logic                                rsp_was_held,
   output logic [rsa_pkg::STAGE_W-1:0]         rsp_stage_out,
   output logic [rsa_pkg::MASK_W-1:0]          rsp_squashed_mask,
   output logic [rsa_pkg::COUNT_W-1:0]         rsp_free_count,
   output logic                                rsp_bad_free
);
   import rsa_pkg::*;

   item_type   push_item, head_item;
   logic       q_push, q_full, q_valid, q_pop;
   result_type rsp_word;

   // front: take the word, decode and range-check it
   rsa_front #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_req_type  (req_req_type),
      .req_seq_num   (req_seq_num),
      .req_thread_id (req_thread_id),
      .req_stage_num (req_stage_num),
      .req_command   (req_command),
      .req_slot_in   (req_slot_in),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   // hold decoded words until the back end is free
   rsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .item      (head_item)
   );

   // back: slot table, free list, squash scan and output register
   rsa_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (head_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_ready (rsp_ready)
   );

   assign rsp_granted       = rsp_word.granted;
   assign rsp_slot_out      = rsp_word.slot_out;
   assign rsp_was_held      = rsp_word.was_held;
   assign rsp_stage_out     = rsp_word.stage_out;
   assign rsp_squashed_mask = rsp_word.squashed_mask;
   assign rsp_free_count    = rsp_word.free_count;
   assign rsp_bad_free      = rsp_word.bad_free;

endmodule
`default_nettype wire
